/* sv/sts_pkg.sv */
// Shared widths, command and status types for the sparse triangular solver.
package sts_pkg;

	localparam int ROW_W     = 10;
	localparam int VAL_W     = 32;
	localparam int ACC_W     = 64;
	localparam int DIV_STEPS = 64;
	localparam int CNT_W     = 6;

	typedef logic [ROW_W-1:0]        row_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic mul;
		logic acc;
		logic num;
		logic div_init;
		logic div_step;
		logic finish;
	} sts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mac_in;
		logic last_in;
		logic last_q;
		logic diag_zero;
		logic out_free;
	} sts_stat_t;

endpackage

/* sv/sts_if.sv */
// Channel interfaces: matrix entry input, solution output and mode write.
interface sts_in_if import sts_pkg::*; ();
	logic valid;
	logic ready;
	row_t row_index;
	row_t column_index;
	val_t entry_value;
	val_t rhs_value;
	logic row_end;

	modport source (output valid, row_index, column_index, entry_value, rhs_value, row_end,
		input ready);
	modport sink (input valid, row_index, column_index, entry_value, rhs_value, row_end,
		output ready);
endinterface

interface sts_out_if import sts_pkg::*; ();
	logic valid;
	logic ready;
	row_t solved_row;
	val_t solution_value;
	logic zero_diagonal;
	logic stray_entry;
	logic saturated;

	modport source (output valid, solved_row, solution_value, zero_diagonal, stray_entry,
		saturated, input ready);
	modport sink (input valid, solved_row, solution_value, zero_diagonal, stray_entry,
		saturated, output ready);
endinterface

interface sts_cfg_if ();
	logic valid;
	logic ready;
	logic upper_mode;

	modport source (output valid, upper_mode, input ready);
	modport sink (input valid, upper_mode, output ready);
endinterface

/* sv/sparse_triangular_solve.sv */
// Top level of the streaming sparse triangular solver (forward or back substitution).
//
// Channels: "item" takes one nonzero matrix entry per beat (row, column, Q16.16 value,
// right-hand side and a row_end mark), rows in solve order. "result" gives one beat per
// row_end entry: the row, its Q16.16 solution and the zero_diagonal, stray_entry and
// saturated flags. "cfg" writes upper_mode (0 lower/ascending, 1 upper/descending);
// write it only while the block is idle. cfg is always ready.
// Sequence: an entry off the diagonal on the solved side goes through the store read,
// the 32x32 multiply and the 64-bit accumulate before the next entry is taken; a
// diagonal, stray or out-of-range entry needs no further step. A row_end entry then
// forms the numerator, sets up the divide, runs the restoring divider at one quotient
// bit per cycle (skipped on a zero diagonal) and loads the result register, which
// then holds the result beat.
// The per-row accumulator, diagonal and stray flag clear on every row end.
// Reset clears the mode to lower, the per-row state and the result valid; the solution
// store is not cleared, so each row may read only columns already solved.
// A stalled result holds its beat; entries keep being taken until the next row end,
// which then waits for the result register to free up.
module sparse_triangular_solve import sts_pkg::*; #(
	parameter int MAX_ROWS = 1024
) (
	input logic clk,
	input logic arst_n,
	sts_in_if.sink    item,
	sts_out_if.source result,
	sts_cfg_if.sink   cfg
);

	sts_cmd_t  cmd;
	sts_stat_t stat;
	logic      in_ready;

	assign item.ready = in_ready;
	assign cfg.ready  = 1'b1;

	// sequence each entry and the per-row divide
	sts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// accumulate, divide and hold the result beat
	sts_dpath #(
		.MAX_ROWS(MAX_ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg.valid),
		.cfg_mode  (cfg.upper_mode),
		.in_row    (item.row_index),
		.in_col    (item.column_index),
		.in_entry  (item.entry_value),
		.in_rhs    (item.rhs_value),
		.in_end    (item.row_end),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_row   (result.solved_row),
		.out_value (result.solution_value),
		.out_zero  (result.zero_diagonal),
		.out_stray (result.stray_entry),
		.out_sat   (result.saturated)
	);

endmodule

/* sv/sts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/sts_ctrl.sv */
// Sequencing state machine for entry accumulate, numerator, divide and result.
module sts_ctrl import sts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sts_stat_t stat,
	output sts_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_NUM,
		S_DSET,
		S_DIV,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd          = '0;
		cmd.accept   = in_ready && in_valid;
		cmd.mul      = (state_q == S_MUL);
		cmd.acc      = (state_q == S_ACC);
		cmd.num      = (state_q == S_NUM);
		cmd.div_init = (state_q == S_DSET);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (stat.mac_in) begin
							state_q <= S_MUL;
						end else if (stat.last_in) begin
							state_q <= S_NUM;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= stat.last_q ? S_NUM : S_IDLE;
				end
				S_NUM: begin
					state_q <= S_DSET;
				end
				S_DSET: begin
					cnt_q   <= '0;
					state_q <= stat.diag_zero ? S_DONE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/sts_dpath.sv */
// Datapath: entry classification, multiply-accumulate, bit-serial divide, result register.
module sts_dpath import sts_pkg::*; #(
	parameter int MAX_ROWS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sts_cmd_t  cmd,
	output sts_stat_t stat,
	input  logic      cfg_valid,
	input  logic      cfg_mode,
	input  row_t      in_row,
	input  row_t      in_col,
	input  val_t      in_entry,
	input  val_t      in_rhs,
	input  logic      in_end,
	output logic      out_valid,
	input  logic      out_ready,
	output row_t      out_row,
	output val_t      out_value,
	output logic      out_zero,
	output logic      out_stray,
	output logic      out_sat
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);

	logic             mode_q;
	logic [ACC_W-1:0] acc_q;
	val_t             diag_q;
	logic             stray_q;
	row_t             row_q;
	logic             row_ok_q;
	val_t             entry_q;
	val_t             rhs_q;
	logic             end_q;
	logic signed [ACC_W-1:0] prod_q;
	logic [ACC_W-1:0] num_q;
	logic [ACC_W-1:0] dq_q;
	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] dmag_q;
	logic             qneg_q;
	logic             zero_q;
	val_t             rd_data;

	logic [16:0]   row_ext;
	logic [16:0]   col_ext;
	logic          in_ok;
	logic          is_diag;
	logic          summed;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [VAL_W:0] rem_sh;
	logic          ge;
	logic [VAL_W:0] rem_sub;
	logic          sat;
	val_t          result;

	// classify the entry on the input side
	always_comb begin
		row_ext = 17'(in_row);
		col_ext = 17'(in_col);
		in_ok   = (row_ext < ROW_LIMIT) && (col_ext < ROW_LIMIT);
		is_diag = (in_col == in_row);
		summed  = mode_q ? (in_col > in_row) : (in_col < in_row);
		rd_addr = col_ext[AW-1:0];
		wr_addr = AW'(row_q);
	end

	// one restoring divide step
	always_comb begin
		rem_sh  = {rem_q, dq_q[ACC_W-1]};
		ge      = rem_sh >= {1'b0, dmag_q};
		rem_sub = rem_sh - {1'b0, dmag_q};
	end

	// clip the quotient magnitude and apply its sign
	always_comb begin
		if (zero_q) begin
			sat    = 1'b0;
			result = '0;
		end else if (qneg_q) begin
			sat    = (|dq_q[ACC_W-1:VAL_W]) || (dq_q[VAL_W-1] && (|dq_q[VAL_W-2:0]));
			result = sat ? val_t'({1'b1, {(VAL_W-1){1'b0}}}) : val_t'(-dq_q[VAL_W-1:0]);
		end else begin
			sat    = |dq_q[ACC_W-1:VAL_W-1];
			result = sat ? val_t'({1'b0, {(VAL_W-1){1'b1}}}) : val_t'(dq_q[VAL_W-1:0]);
		end
	end

	assign stat.mac_in    = in_ok && !is_diag && summed;
	assign stat.last_in   = in_end;
	assign stat.last_q    = end_q;
	assign stat.diag_zero = (diag_q == '0);
	assign stat.out_free  = !out_valid || out_ready;

	sts_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ROWS)
	) u_store (
		.clk   (clk),
		.we    (cmd.finish && row_ok_q),
		.waddr (wr_addr),
		.wdata (result),
		.re    (cmd.accept && stat.mac_in),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// control and per-row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			acc_q     <= '0;
			diag_q    <= '0;
			stray_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_mode;
			end
			if (cmd.accept) begin
				if (!in_ok || (!is_diag && !summed)) begin
					stray_q <= 1'b1;
				end else if (is_diag) begin
					diag_q <= in_entry;
				end
			end
			if (cmd.acc) begin
				acc_q <= acc_q + prod_q;
			end
			if (cmd.finish) begin
				acc_q     <= '0;
				diag_q    <= '0;
				stray_q   <= 1'b0;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q    <= in_row;
			row_ok_q <= row_ext < ROW_LIMIT;
			entry_q  <= in_entry;
			rhs_q    <= in_rhs;
			end_q    <= in_end;
		end
		if (cmd.mul) begin
			prod_q <= ACC_W'(entry_q) * ACC_W'(rd_data);
		end
		if (cmd.num) begin
			num_q <= {{(ACC_W-VAL_W-16){rhs_q[VAL_W-1]}}, rhs_q, 16'h0000} - acc_q;
		end
		if (cmd.div_init) begin
			dq_q   <= num_q[ACC_W-1] ? (ACC_W'(0) - num_q) : num_q;
			rem_q  <= '0;
			dmag_q <= diag_q[VAL_W-1] ? (VAL_W'(0) - diag_q) : diag_q;
			qneg_q <= num_q[ACC_W-1] ^ diag_q[VAL_W-1];
			zero_q <= (diag_q == '0);
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
			dq_q  <= {dq_q[ACC_W-2:0], ge};
		end
		if (cmd.finish) begin
			out_row   <= row_q;
			out_value <= result;
			out_zero  <= zero_q;
			out_stray <= stray_q;
			out_sat   <= sat;
		end
	end

endmodule

/* test/solution_tracker.sv */
// Solution tracker: watches the solver channels, predicts each row solution and compares.
`timescale 1ns / 100ps
module solution_tracker import sts_pkg::*; #(
	parameter int MAX_ROWS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	sts_in_if    item,
	sts_out_if   result,
	sts_cfg_if   cfg,
	output int   fail_count,
	output int   pending,
	output int   rows_checked,
	output int   flagged_rows
);

	typedef struct {
		row_t row;
		val_t value;
		logic zero_diag;
		logic stray;
		logic sat;
	} solution_t;

	val_t        solved_x [MAX_ROWS];
	logic [63:0] row_sum;
	val_t        row_diag;
	logic        row_stray;
	logic        solve_upper;
	solution_t   awaited_solutions [$];

	// Fold one accepted entry into the row state; on row end, queue the solution.
	function automatic void absorb_entry(row_t row, row_t col, val_t value, val_t rhs,
			logic last);
		logic signed [63:0] term_a, term_b;
		logic [63:0]        numer, nmag, dmag, quot;
		logic               qneg;
		solution_t          sol;

		if (int'(row) >= MAX_ROWS || int'(col) >= MAX_ROWS) begin
			row_stray = 1'b1;
		end else if (col == row) begin
			row_diag = value;
		end else if ((!solve_upper && col < row) || (solve_upper && col > row)) begin
			term_a  = value;
			term_b  = solved_x[col];
			row_sum = row_sum + term_a * term_b;
		end else begin
			row_stray = 1'b1;
		end
		if (!last)
			return;

		sol.row       = row;
		sol.value     = '0;
		sol.zero_diag = 1'b0;
		sol.stray     = row_stray;
		sol.sat       = 1'b0;
		if (row_diag == 0) begin
			sol.zero_diag = 1'b1;
		end else begin
			// numerator in Q32.32, divided by the Q16.16 diagonal with truncation
			term_a = rhs;
			numer  = (term_a << 16) - row_sum;
			nmag   = numer[63] ? -numer : numer;
			term_b = row_diag;
			dmag   = row_diag[31] ? -term_b : term_b;
			quot   = nmag / dmag;
			qneg   = numer[63] ^ row_diag[31];
			if (qneg) begin
				if (quot > 64'h8000_0000) begin
					quot    = 64'h8000_0000;
					sol.sat = 1'b1;
				end
				sol.value = -quot[31:0];
			end else begin
				if (quot > 64'h7FFF_FFFF) begin
					quot    = 64'h7FFF_FFFF;
					sol.sat = 1'b1;
				end
				sol.value = quot[31:0];
			end
		end
		if (int'(row) < MAX_ROWS)
			solved_x[row] = sol.value;
		awaited_solutions.push_back(sol);
		row_sum   = '0;
		row_diag  = '0;
		row_stray = 1'b0;
	endfunction

	function automatic void check_solution();
		solution_t want;

		if (awaited_solutions.size() == 0) begin
			$display("%0t: result beat for row %0d while no solution is awaited",
				$time, result.solved_row);
			fail_count++;
			return;
		end
		want = awaited_solutions.pop_front();
		rows_checked++;
		if (result.solved_row !== want.row || result.solution_value !== want.value ||
				result.zero_diagonal !== want.zero_diag || result.stray_entry !== want.stray ||
				result.saturated !== want.sat) begin
			$display("%0t: expected row %0d x %h zero %b stray %b sat %b", $time,
				want.row, want.value, want.zero_diag, want.stray, want.sat);
			$display("%0t:   actual row %0d x %h zero %b stray %b sat %b", $time,
				result.solved_row, result.solution_value, result.zero_diagonal,
				result.stray_entry, result.saturated);
			fail_count++;
		end else if (want.zero_diag || want.stray || want.sat) begin
			flagged_rows++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum      = '0;
			row_diag     = '0;
			row_stray    = 1'b0;
			solve_upper  = 1'b0;
			fail_count   = 0;
			rows_checked = 0;
			flagged_rows = 0;
			awaited_solutions.delete();
		end else begin
			if (result.valid && result.ready)
				check_solution();
			if (cfg.valid && cfg.ready)
				solve_upper = cfg.upper_mode;
			if (item.valid && item.ready)
				absorb_entry(item.row_index, item.column_index, item.entry_value,
					item.rhs_value, item.row_end);
		end
		pending = awaited_solutions.size();
	end

endmodule

/* test/sparse_triangular_solve_test.sv */
// Testbench top: directed and random substitution traffic for the triangular solver.
`timescale 1ns / 100ps
module sparse_triangular_solve_test;
	import sts_pkg::*;

	localparam int   MAX_ROWS   = 1024;
	localparam int   ENTRY_GOAL = 700;
	localparam int   PHASES     = 6;
	// cycles to let pass after the last result before touching the mode register
	localparam int   SETTLE     = 80;
	localparam logic LOWER      = 1'b0;
	localparam logic UPPER      = 1'b1;
	localparam val_t Q_ONE      = 32'h0001_0000;
	localparam val_t Q_MAX      = 32'h7FFF_FFFF;
	localparam val_t Q_MIN      = 32'h8000_0000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sts_in_if  item_ch ();
	sts_out_if result_ch ();
	sts_cfg_if cfg_ch ();

	int   fail_count, pending, rows_checked, flagged_rows;
	bit   solved_known [MAX_ROWS];
	logic mode_now = LOWER;
	int   entries_sent = 0;
	int   send_calm = 0;
	int   take_calm = 0;
	logic phase_modes [PHASES] = '{LOWER, UPPER, LOWER, UPPER, UPPER, LOWER};

	sparse_triangular_solve #(.MAX_ROWS(MAX_ROWS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	solution_tracker #(.MAX_ROWS(MAX_ROWS)) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.cfg          (cfg_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.rows_checked (rows_checked),
		.flagged_rows (flagged_rows)
	);

	always #6 clk = ~clk;

	// Draw an idle gap of 0..15 cycles; now and then open a calm stretch with no gaps.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 15);
	endfunction

	// Off-diagonal values: mostly small so solutions stay in range, some full-width.
	function automatic val_t pick_entry();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return val_t'($urandom_range(0, 32'h8_0000)) - val_t'(32'h4_0000);
		if (sel < 9)
			return val_t'($urandom);
		return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
	endfunction

	// Diagonals: mostly 0.5 to 4.0 in magnitude, some full-width, some tiny to saturate.
	function automatic val_t pick_diag();
		int   sel;
		val_t mag;
		sel = $urandom_range(0, 19);
		if (sel < 15)
			mag = val_t'($urandom_range(32'h8000, 32'h4_0000));
		else if (sel < 18)
			return val_t'($urandom);
		else
			mag = val_t'($urandom_range(1, 255));
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic val_t pick_rhs();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 14)
			return val_t'($urandom_range(0, 32'h80_0000)) - val_t'(32'h40_0000);
		if (sel < 19)
			return val_t'($urandom);
		return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
	endfunction

	// Swap a column that would read a never-solved row for the diagonal instead.
	function automatic row_t safe_col(row_t row, row_t col);
		logic reads_store;
		reads_store = (mode_now == LOWER) ? (col < row) : (col > row);
		if (reads_store && !solved_known[col])
			return row;
		return col;
	endfunction

	// Drive one entry beat after a random gap and hold it until it is taken.
	task automatic send_entry(input row_t row, input row_t col, input val_t value,
			input val_t rhs, input logic last);
		int gap;
		gap = draw_gap(send_calm);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.row_index    <= row;
		item_ch.column_index <= col;
		item_ch.entry_value  <= value;
		item_ch.rhs_value    <= rhs;
		item_ch.row_end      <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		entries_sent++;
		// a finished row becomes readable by later rows
		if (last && int'(row) < MAX_ROWS)
			solved_known[row] = 1'b1;
	endtask

	// Drop valid and hold until every awaited solution has come back.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Write the mode only with the block idle: drain, let the divider settle, then write.
	task automatic write_mode(input logic mode);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.upper_mode <= mode;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		mode_now = mode;
	endtask

	// Lower (forward) mode: extremes, missing and zero diagonals, strays, repeated
	// diagonals, foreign row indices mid-row, both saturation signs, accumulator wrap.
	task automatic directed_lower();
		send_entry(10'd0, 10'd0, Q_ONE, 32'h0005_0000, 1'b1);
		send_entry(10'd1, 10'd0, Q_MAX, 32'h0, 1'b0);
		send_entry(10'd1, 10'd1, Q_MIN, Q_MIN, 1'b1);
		send_entry(10'd2, 10'd0, -Q_ONE, 32'h0003_0000, 1'b1);
		send_entry(10'd3, 10'd1023, 32'h1234_5678, 32'h0, 1'b0);
		send_entry(10'd3, 10'd3, 32'h0000_0001, Q_MAX, 1'b1);
		send_entry(10'd4, 10'd4, 32'h0, Q_ONE, 1'b1);
		send_entry(10'd5, 10'd5, 32'h0002_0000, 32'h0, 1'b0);
		send_entry(10'd5, 10'd5, 32'h0003_0000, 32'h0, 1'b0);
		send_entry(10'd5, 10'd0, 32'h0000_8000, 32'h0007_0000, 1'b1);
		send_entry(10'd1023, 10'd0, Q_ONE, 32'h0, 1'b0);
		send_entry(10'd6, 10'd6, -Q_ONE, -32'sh0002_0000, 1'b1);
		send_entry(10'd7, 10'd7, 32'h0000_0001, Q_MIN, 1'b1);
		// four products of 2^62 wrap the 64-bit sum back to zero
		repeat (4) send_entry(10'd9, 10'd7, Q_MIN, 32'h0, 1'b0);
		send_entry(10'd9, 10'd9, Q_ONE, 32'h0, 1'b1);
	endtask

	// Upper (back) mode: top row saturates positive, next row reads it and has a stray.
	task automatic directed_upper();
		send_entry(10'd1023, 10'd1023, -Q_ONE, Q_MIN, 1'b1);
		send_entry(10'd1022, 10'd1023, Q_ONE, 32'h0, 1'b0);
		send_entry(10'd1022, 10'd0, Q_ONE, 32'h0, 1'b0);
		send_entry(10'd1022, 10'd1022, Q_MAX, Q_MAX, 1'b1);
	endtask

	// One row of a well-formed system: solved-side columns from [lo, hi], an occasional
	// far or stray column, a diagonal (sometimes missing, zero or doubled) at a random spot.
	task automatic random_row(input row_t row, input int lo, input int hi);
		row_t cols [10];
		val_t vals [10];
		int   count, kind, pos, i;
		row_t tcol;
		val_t tval;

		count = 0;
		if (lo <= hi) begin
			repeat ($urandom_range(0, 4)) begin
				cols[count] = row_t'($urandom_range(lo, hi));
				vals[count] = pick_entry();
				count++;
			end
		end
		if ($urandom_range(0, 5) == 0) begin
			cols[count] = safe_col(row, row_t'($urandom_range(0, MAX_ROWS - 1)));
			vals[count] = pick_entry();
			count++;
		end
		kind = $urandom_range(0, 19);
		if (kind != 0) begin
			repeat ((kind == 2) ? 2 : 1) begin
				cols[count] = row;
				vals[count] = (kind == 1) ? val_t'(0) : pick_diag();
				count++;
				pos = $urandom_range(0, count - 1);
				tcol = cols[pos];
				tval = vals[pos];
				cols[pos] = cols[count - 1];
				vals[pos] = vals[count - 1];
				cols[count - 1] = tcol;
				vals[count - 1] = tval;
			end
		end
		if (count == 0) begin
			cols[0] = row;
			vals[0] = pick_diag();
			count = 1;
		end
		for (i = 0; i < count; i++)
			send_entry(row, cols[i], vals[i], pick_rhs(), i == count - 1);
	endtask

	// Mostly whole systems in solve order; the rest noise rows and dangling entries
	// that spill into whichever row ends next.
	task automatic random_phase(input int goal);
		int   pick, n, base, r;
		row_t nrow;

		while (entries_sent < goal) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
				if (mode_now == LOWER) begin
					base = $urandom_range(0, MAX_ROWS - n);
					for (r = base; r < base + n; r++)
						random_row(row_t'(r), base, r - 1);
				end else begin
					base = $urandom_range(n - 1, MAX_ROWS - 1);
					for (r = base; r > base - n; r--)
						random_row(row_t'(r), r + 1, base);
				end
			end else if (pick < 18) begin
				nrow = row_t'($urandom_range(0, MAX_ROWS - 1));
				repeat ($urandom_range(0, 2))
					send_entry(nrow, safe_col(nrow, row_t'($urandom)), val_t'($urandom),
						val_t'($urandom), 1'b0);
				send_entry(nrow, safe_col(nrow, row_t'($urandom)), val_t'($urandom),
					val_t'($urandom), 1'b1);
			end else begin
				nrow = row_t'($urandom_range(0, MAX_ROWS - 1));
				send_entry(nrow, safe_col(nrow, row_t'($urandom)), pick_entry(),
					val_t'($urandom), 1'b0);
			end
			// now and then hold the input until the block has caught up
			if ($urandom_range(0, 149) == 0)
				wait_drained();
		end
	endtask

	// Result side: stall a random number of cycles once a beat shows, or take it at once.
	initial begin : result_taker
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_gap(take_calm);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				@(posedge clk);
				while (!result_ch.valid) @(posedge clk);
				repeat (stall - 1) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int p;
		// drive every input to a known value before the first edge
		item_ch.valid        = 1'b0;
		item_ch.row_index    = '0;
		item_ch.column_index = '0;
		item_ch.entry_value  = '0;
		item_ch.rhs_value    = '0;
		item_ch.row_end      = 1'b0;
		result_ch.ready      = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.upper_mode    = LOWER;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_mode(LOWER);
		directed_lower();
		write_mode(UPPER);
		directed_upper();

		for (p = 0; p < PHASES; p++) begin
			write_mode(phase_modes[p]);
			random_phase(entries_sent + ENTRY_GOAL / PHASES);
		end

		// let the last row end work through the divider and out
		wait_drained();
		repeat (SETTLE + 20) @(posedge clk);

		$display("Sent %0d entries in both substitution orders with random gaps on both sides,",
			entries_sent);
		$display("checked %0d solved rows, %0d of them with a flag raised.", rows_checked,
			flagged_rows);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Stop a hung run long after the slowest correct one would have ended.
	initial begin : watchdog
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
